// File: src/cbpa_pkg.sv
// ----------------------------------------------------------------------------
// cbpa_pkg: shared types and constants of the block pool allocator
// Field widths, request and response layouts, action and status codes.
// ----------------------------------------------------------------------------
package cbpa_pkg;

    localparam int POOL_BLOCKS_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 32;

    localparam int ACTION_W  = 2;
    localparam int BCOUNT_W  = 8;
    localparam int BYTE_W    = 16;
    localparam int INDEX_W   = 6;

    localparam int STATUS_W  = 2;
    localparam int START_W   = 6;
    localparam int OFFSET_W  = 11;
    localparam int MARK_W    = 7;
    localparam int FREE_W    = 7;
    localparam int USED_W    = 7;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC_BLK  = 2'd0,
        ACT_ALLOC_BYTE = 2'd1,
        ACT_FREE       = 2'd2,
        ACT_READ       = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_TOO_BIG = 2'd2,
        ST_NO_ROOM = 2'd3
    } t_status;

    // Packed lowest field last, so the first field lands in the low bits.
    typedef struct packed {
        logic [INDEX_W-1:0]  blk_idx;
        logic [BYTE_W-1:0]   byte_count;
        logic [BCOUNT_W-1:0] block_count;
        t_action             action;
    } t_in_req;

    typedef struct packed {
        logic [USED_W-1:0]   used_blocks;
        logic [FREE_W-1:0]   free_blocks;
        logic [MARK_W-1:0]   block_mark;
        logic [OFFSET_W-1:0] byte_offset;
        logic [START_W-1:0]  start_block;
        t_status             status;
    } t_out_rsp;

endpackage

// File: src/cbpa_ram.sv
// ----------------------------------------------------------------------------
// cbpa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbpa_ram #(
    parameter int WIDTH = cbpa_pkg::MARK_W,
    parameter int DEPTH = cbpa_pkg::POOL_BLOCKS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/cbpa_div.sv
// ----------------------------------------------------------------------------
// cbpa_div: divider by a constant through reciprocal multiplication
// One constant multiply and shift, result registered; o_done pulses the
// cycle after i_start.
// ----------------------------------------------------------------------------
module cbpa_div #(
    parameter int NUM_W   = 17,
    parameter int DIVISOR = cbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    // floor(n / d) equals floor(n * m / 2^(NUM_W + L)) for every n below 2^NUM_W,
    // with L = ceil(log2 d) and m = ceil(2^(NUM_W + L) / d)
    localparam int              SHIFT_L = $clog2(DIVISOR);
    localparam int              SHIFT   = NUM_W + SHIFT_L;
    localparam int              MUL_W   = NUM_W + 2;
    localparam int              PROD_W  = NUM_W + MUL_W;
    localparam longint unsigned RECIP   =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

    logic              r_done;
    logic [NUM_W-1:0]  r_quot;
    logic [PROD_W-1:0] product;

    assign product = PROD_W'(i_num) * PROD_W'(RECIP_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_quot <= NUM_W'(product >> SHIFT);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: src/contiguous_block_pool_allocator.sv
// Sequence, accepting edge to response valid: allocate by blocks scans first-fit (the
//   whole pool when no run fits), stamps each granted block, then loads the response;
//   bytes divide first; free reads the mark and frees each block; read reads it; zero,
//   oversized, out-of-range requests skip to the response. A held one waits for the sink.
// Throughput: one request at a time; the next is taken the cycle after the response loads.
// Reset: synchronous, active low; clears every block's live flag, the used count and the output valid.
// ----------------------------------------------------------------------------
// contiguous_block_pool_allocator: first-fit contiguous block allocator
// Keeps a map of block marks (0 free, else run length) in a RAM with one
// flop per block telling which marks are live, scans it first-fit with a
// small sequencer, and answers allocate, free and read requests.
// ----------------------------------------------------------------------------
module contiguous_block_pool_allocator #(
    parameter int POOL_BLOCKS = cbpa_pkg::POOL_BLOCKS_DEF,
    parameter int BLOCK_BYTES = cbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request: action, block_count, byte_count, blk_idx (from bit 0 up)
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [cbpa_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // response: status, start_block, byte_offset, block_mark, free_blocks,
    // used_blocks (from bit 0 up)
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [cbpa_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    import cbpa_pkg::*;

    localparam int IDX_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int CNT_W = $clog2(POOL_BLOCKS + 1);
    // width of the rounded-up byte count before division
    localparam int NUM_W = $clog2((2 ** BYTE_W) - 1 + BLOCK_BYTES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_MARK = 7'b0001000,
        S_RDAT = 7'b0010000,
        S_FCLR = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // sequencer state
    t_state                r_state,     n_state;
    logic [IDX_W-1:0]      r_ptr,       n_ptr;
    logic [CNT_W-1:0]      r_cnt,       n_cnt;
    logic [CNT_W-1:0]      r_run,       n_run;
    logic [IDX_W-1:0]      r_run_start, n_run_start;
    logic [CNT_W-1:0]      r_want,      n_want;
    t_action               r_action,    n_action;

    // pool state: live flag per block, used count
    logic [POOL_BLOCKS-1:0] r_valid,    n_valid;
    logic [CNT_W-1:0]      r_used,      n_used;

    // result under construction
    t_status               r_status,    n_status;
    logic [IDX_W-1:0]      r_start,     n_start;
    logic [MARK_W-1:0]     r_mark,      n_mark;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_out_rsp              r_out,       n_out;

    t_in_req               req;
    logic                  accept;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_W-1:0]      div_num;
    logic [NUM_W-1:0]      div_quot;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [MARK_W-1:0]     ram_rdata;

    logic                  blk_free;
    logic                  last_blk;
    logic [CNT_W-1:0]      run_inc;
    logic [IDX_W-1:0]      cur_start;
    logic [CNT_W:0]        used_sum;
    logic [MARK_W-1:0]     rd_mark;
    logic [NUM_W-1:0]      room;
    logic [NUM_W-1:0]      free_len;

    assign req        = t_in_req'(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    assign div_num = NUM_W'(req.byte_count) + NUM_W'(BLOCK_BYTES - 1);

    cbpa_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Mark RAM: written while a granted run is stamped, read for free/read.
    // In idle the read address comes straight from the request.
    assign ram_we    = (r_state == S_MARK);
    assign ram_raddr = (r_state == S_IDLE) ? IDX_W'(req.blk_idx) : r_ptr;

    cbpa_ram #(
        .WIDTH (MARK_W),
        .DEPTH (POOL_BLOCKS),
        .AW    (IDX_W)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (MARK_W'(r_want)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Scan helpers: a block is free when its mark is not live.
    assign blk_free  = !r_valid[r_ptr];
    assign last_blk  = (r_ptr == IDX_W'(POOL_BLOCKS - 1));
    assign run_inc   = r_run + 1'b1;
    assign cur_start = (r_run == '0) ? r_ptr : r_run_start;
    assign used_sum  = {1'b0, r_used} + {1'b0, r_want};

    // Free helpers: clip the run at the end of the pool.
    assign rd_mark  = r_valid[r_ptr] ? ram_rdata : '0;
    assign room     = NUM_W'(POOL_BLOCKS) - NUM_W'(r_ptr);
    assign free_len = (NUM_W'(rd_mark) > room) ? room : NUM_W'(rd_mark);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_want      = r_want;
        n_action    = r_action;
        n_valid     = r_valid;
        n_used      = r_used;
        n_status    = r_status;
        n_start     = r_start;
        n_mark      = r_mark;
        n_out       = r_out;
        div_start   = 1'b0;
        // drop the held response once the sink takes it
        n_out_valid = r_out_valid && !i_m_tready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action = req.action;
                    n_status = ST_OK;
                    n_start  = '0;
                    n_mark   = '0;
                    n_ptr    = IDX_W'(req.blk_idx);
                    case (req.action)
                        ACT_ALLOC_BLK: begin
                            if (req.block_count == '0) begin
                                n_status = ST_ZERO;
                                n_state  = S_DONE;
                            end else if (NUM_W'(req.block_count) > NUM_W'(POOL_BLOCKS)) begin
                                n_status = ST_TOO_BIG;
                                n_state  = S_DONE;
                            end else begin
                                n_want  = CNT_W'(req.block_count);
                                n_ptr   = '0;
                                n_run   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_ALLOC_BYTE: begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        default: begin
                            // free and read share the index check and the RAM read
                            if (NUM_W'(req.blk_idx) >= NUM_W'(POOL_BLOCKS)) begin
                                n_status = ST_TOO_BIG;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RDAT;
                            end
                        end
                    endcase
                end
            end

            S_DIV: begin
                if (div_done) begin
                    if (div_quot == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else if (div_quot > NUM_W'(POOL_BLOCKS)) begin
                        n_status = ST_TOO_BIG;
                        n_state  = S_DONE;
                    end else begin
                        n_want  = CNT_W'(div_quot);
                        n_ptr   = '0;
                        n_run   = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // grow the current free run; the first run to reach the
                // wanted length is the lowest-indexed fit
                if (blk_free) begin
                    if (run_inc == r_want) begin
                        n_start = cur_start;
                        n_ptr   = cur_start;
                        n_cnt   = r_want;
                        n_state = S_MARK;
                    end else begin
                        n_run       = run_inc;
                        n_run_start = cur_start;
                        n_ptr       = r_ptr + 1'b1;
                        if (last_blk) begin
                            n_status = ST_NO_ROOM;
                            n_state  = S_DONE;
                        end
                    end
                end else begin
                    n_run = '0;
                    n_ptr = r_ptr + 1'b1;
                    if (last_blk) begin
                        n_status = ST_NO_ROOM;
                        n_state  = S_DONE;
                    end
                end
            end

            S_MARK: begin
                // stamp one block per cycle; a mark that truncates to zero
                // leaves the block free
                n_valid[r_ptr] = (MARK_W'(r_want) != '0);
                n_ptr          = r_ptr + 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_used  = (used_sum > (CNT_W+1)'(POOL_BLOCKS)) ?
                              CNT_W'(POOL_BLOCKS) : CNT_W'(used_sum);
                    n_mark  = MARK_W'(r_want);
                    n_state = S_DONE;
                end
            end

            S_RDAT: begin
                if (r_action == ACT_READ) begin
                    n_mark  = rd_mark;
                    n_state = S_DONE;
                end else begin
                    n_mark = MARK_W'(free_len);
                    n_cnt  = CNT_W'(free_len);
                    n_want = CNT_W'(free_len);
                    if (free_len == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FCLR;
                    end
                end
            end

            S_FCLR: begin
                // release one block per cycle, lowering the used count with the last one
                n_valid[r_ptr] = 1'b0;
                n_ptr          = r_ptr + 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_used  = (r_used > r_want) ? (r_used - r_want) : '0;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.start_block = START_W'(r_start);
                    n_out.byte_offset = OFFSET_W'(int'(r_start) * BLOCK_BYTES);
                    n_out.block_mark  = r_mark;
                    n_out.free_blocks = FREE_W'(POOL_BLOCKS - int'(r_used));
                    n_out.used_blocks = USED_W'(r_used);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_ptr       <= n_ptr;
        r_cnt       <= n_cnt;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_want      <= n_want;
        r_action    <= n_action;
        r_status    <= n_status;
        r_start     <= n_start;
        r_mark      <= n_mark;
        r_out       <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule
